>>> rtl/maxtree_area_filter_macros.svh
// assertion macros shared by the area filter modules
`ifndef MAXTREE_AREA_FILTER_MACROS_SVH
`define MAXTREE_AREA_FILTER_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define MTAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define MTAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mtaf_pkg.sv
// shared widths, defaults and controller/datapath command and status types
`default_nettype none

package mtaf_pkg;

    localparam int IDX_IN_W      = 12;
    localparam int AREA_W        = 13;
    localparam int GREY_IN_W     = 16;
    localparam int NODES_DEF     = 4096;
    localparam int GREY_BITS_DEF = 16;

    localparam logic [AREA_W-1:0] THR_RST = AREA_W'(1);

    typedef struct packed {
        logic take;
        logic wrap_q;
        logic wrap_r;
        logic node_wr;
        logic clr_wr;
        logic rd_node;
        logic rd_par;
        logic save_w;
        logic step;
        logic val_calc;
        logic wb_wr;
        logic wb_rd;
        logic wb_adv;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic stop;
        logic climb;
        logic wb_last;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/mtaf_ifs.sv
// valid/ready channel interfaces for items, results and the threshold register
`default_nettype none

interface mtaf_in_if;
    import mtaf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [IDX_IN_W-1:0]  node_index;
    logic [IDX_IN_W-1:0]  parent_index;
    logic                 has_parent;
    logic [AREA_W-1:0]    area;
    logic [GREY_IN_W-1:0] grey;

    modport source (output valid, op, node_index, parent_index, has_parent, area, grey,
                    input ready);
    modport sink (input valid, op, node_index, parent_index, has_parent, area, grey,
                  output ready);
endinterface

interface mtaf_out_if;
    import mtaf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_IN_W-1:0]  out_index;
    logic [GREY_IN_W-1:0] filtered_value;

    modport source (output valid, out_index, filtered_value, input ready);
    modport sink (input valid, out_index, filtered_value, output ready);
endinterface

interface mtaf_cfg_if;
    import mtaf_pkg::*;
    logic              valid;
    logic              ready;
    logic [AREA_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/mtaf_ctrl.sv
// controller: sequences the reset clear pass and the load, climb, write-back and result beats
`default_nettype none
`include "maxtree_area_filter_macros.svh"

module mtaf_ctrl
    import mtaf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WRAP1 = 4'd2;
    localparam logic [3:0] S_WRAP2 = 4'd3;
    localparam logic [3:0] S_DISP  = 4'd4;
    localparam logic [3:0] S_RDW   = 4'd5;
    localparam logic [3:0] S_RDP   = 4'd6;
    localparam logic [3:0] S_VAL   = 4'd7;
    localparam logic [3:0] S_WB    = 4'd8;
    localparam logic [3:0] S_WBR   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_WRAP1;
                end
            end
            S_WRAP1: begin
                o_cmd.wrap_q = 1'b1;
                n_state      = S_WRAP2;
            end
            S_WRAP2: begin
                o_cmd.wrap_r = 1'b1;
                n_state      = S_DISP;
            end
            S_DISP: begin
                if (!i_sts.op) begin
                    o_cmd.node_wr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_node = 1'b1;
                    n_state       = S_RDW;
                end
            end
            S_RDW: begin
                o_cmd.save_w = 1'b1;
                if (i_sts.stop) begin
                    n_state = S_VAL;
                end else begin
                    o_cmd.rd_par = 1'b1;
                    n_state      = S_RDP;
                end
            end
            S_RDP: begin
                if (i_sts.climb) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RDW;
                end else begin
                    n_state = S_VAL;
                end
            end
            S_VAL: begin
                o_cmd.val_calc = 1'b1;
                n_state        = S_WB;
            end
            S_WB: begin
                o_cmd.wb_wr = 1'b1;
                if (i_sts.wb_last) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.wb_rd = 1'b1;
                    n_state     = S_WBR;
                end
            end
            S_WBR: begin
                o_cmd.wb_adv = 1'b1;
                n_state      = S_WB;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `MTAF_ASSERT_NEXT(a_load_no_result, (r_state == S_DISP) && !i_sts.op, r_state == S_IDLE,
        "load beat did not return to idle")
    `MTAF_ASSERT_NOW(a_result_slot_free, o_cmd.out_load, i_sts.out_free,
        "result loaded over a waiting beat")

endmodule

`default_nettype wire

>>> rtl/mtaf_dp.sv
// datapath: node and filter memories, index wrap, climb and write-back registers
`default_nettype none
`include "maxtree_area_filter_macros.svh"

module mtaf_dp
    import mtaf_pkg::*;
#(
    parameter int NODES     = NODES_DEF,
    parameter int GREY_BITS = GREY_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_item_op,
    input  wire logic [IDX_IN_W-1:0]  i_item_node_index,
    input  wire logic [IDX_IN_W-1:0]  i_item_parent_index,
    input  wire logic                 i_item_has_parent,
    input  wire logic [AREA_W-1:0]    i_item_area,
    input  wire logic [GREY_IN_W-1:0] i_item_grey,
    input  wire logic                 i_cfg_valid,
    input  wire logic [AREA_W-1:0]    i_cfg_data,
    output logic                      o_cfg_ready,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [IDX_IN_W-1:0]       o_out_index,
    output logic [GREY_IN_W-1:0]      o_out_value,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int STEP_W = IDX_W + 1;
    localparam int NODE_W = IDX_W + 1 + AREA_W + GREY_BITS;
    localparam int FILT_W = GREY_BITS + 1;
    localparam int RCP_SH = IDX_IN_W + ((IDX_W < IDX_IN_W) ? IDX_W : IDX_IN_W);
    localparam int RCP_M  = ((1 << RCP_SH) + NODES - 1) / NODES;
    localparam int PROD_W = IDX_IN_W + RCP_SH;
    localparam logic [IDX_IN_W-1:0] WRAP_N =
        IDX_IN_W'((NODES < (1 << IDX_IN_W)) ? NODES : 0);

    logic [NODE_W-1:0] r_node_mem [NODES];
    logic [FILT_W-1:0] r_filt_mem [NODES];

    logic                 r_op;
    logic [IDX_IN_W-1:0]  r_raw_idx;
    logic [IDX_IN_W-1:0]  r_raw_par;
    logic                 r_hasp;
    logic [AREA_W-1:0]    r_area;
    logic [GREY_BITS-1:0] r_grey;
    logic [IDX_IN_W-1:0]  r_q_idx;
    logic [IDX_IN_W-1:0]  r_q_par;
    logic [IDX_W-1:0]     r_node;
    logic [IDX_W-1:0]     r_par;
    logic [AREA_W-1:0]    r_thr;
    logic [IDX_W-1:0]     r_clr;
    logic [NODE_W-1:0]    r_rd_node;
    logic [FILT_W-1:0]    r_rd_filt;
    logic [AREA_W-1:0]    r_w_area;
    logic [GREY_BITS-1:0] r_w_grey;
    logic                 r_w_fdone;
    logic [GREY_BITS-1:0] r_w_fval;
    logic [STEP_W-1:0]    r_steps;
    logic [STEP_W-1:0]    r_wb_cnt;
    logic [IDX_W-1:0]     r_u;
    logic [GREY_BITS-1:0] r_val;
    logic                 r_out_valid;
    logic [IDX_IN_W-1:0]  r_out_index;
    logic [GREY_IN_W-1:0] r_out_value;

    logic [PROD_W-1:0]    w_prod_idx;
    logic [PROD_W-1:0]    w_prod_par;
    logic [IDX_IN_W-1:0]  w_rem_idx;
    logic [IDX_IN_W-1:0]  w_rem_par;
    logic [IDX_W-1:0]     w_rd_parent;
    logic                 w_rd_pvalid;
    logic [GREY_BITS-1:0] w_rd_grey;
    logic [AREA_W-1:0]    w_rd_area;
    logic                 w_rd_fdone;
    logic [GREY_BITS-1:0] w_rd_fval;
    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_fw_en;
    logic [IDX_W-1:0]     w_fw_addr;
    logic [FILT_W-1:0]    w_fw_data;

    // index wrap: reciprocal multiply, then subtract
    assign w_prod_idx = PROD_W'(r_raw_idx) * PROD_W'(RCP_M);
    assign w_prod_par = PROD_W'(r_raw_par) * PROD_W'(RCP_M);
    assign w_rem_idx  = r_raw_idx - IDX_IN_W'(r_q_idx * WRAP_N);
    assign w_rem_par  = r_raw_par - IDX_IN_W'(r_q_par * WRAP_N);

    assign w_rd_grey   = r_rd_node[GREY_BITS-1:0];
    assign w_rd_area   = r_rd_node[GREY_BITS +: AREA_W];
    assign w_rd_pvalid = r_rd_node[GREY_BITS + AREA_W];
    assign w_rd_parent = r_rd_node[NODE_W-1 -: IDX_W];
    assign w_rd_fval   = r_rd_filt[GREY_BITS-1:0];
    assign w_rd_fdone  = r_rd_filt[GREY_BITS];

    assign w_rd_en = i_cmd.rd_node | i_cmd.rd_par | i_cmd.wb_rd;
    assign w_fw_en = i_cmd.clr_wr | i_cmd.node_wr | i_cmd.wb_wr;

    always_comb begin
        w_rd_addr = r_node;
        if (i_cmd.rd_par) begin
            w_rd_addr = w_rd_parent;
        end else if (i_cmd.wb_rd) begin
            w_rd_addr = r_u;
        end
    end

    always_comb begin
        w_fw_addr = r_node;
        w_fw_data = '0;
        if (i_cmd.clr_wr) begin
            w_fw_addr = r_clr;
        end else if (i_cmd.wb_wr) begin
            w_fw_addr = r_u;
            w_fw_data = {1'b1, r_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr) begin
            r_node_mem[r_node] <= {r_par, r_hasp, r_area, r_grey};
        end
        if (w_rd_en) begin
            r_rd_node <= r_node_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fw_en) begin
            r_filt_mem[w_fw_addr] <= w_fw_data;
        end
        if (w_rd_en) begin
            r_rd_filt <= r_filt_mem[w_rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op      <= i_item_op;
            r_raw_idx <= i_item_node_index;
            r_raw_par <= i_item_parent_index;
            r_hasp    <= i_item_has_parent;
            r_area    <= i_item_area;
            r_grey    <= i_item_grey[GREY_BITS-1:0];
        end
        if (i_cmd.wrap_q) begin
            r_q_idx <= IDX_IN_W'(w_prod_idx >> RCP_SH);
            r_q_par <= IDX_IN_W'(w_prod_par >> RCP_SH);
        end
        if (i_cmd.wrap_r) begin
            r_node <= IDX_W'(w_rem_idx);
            r_par  <= IDX_W'(w_rem_par);
        end
        if (i_cmd.save_w) begin
            r_w_area  <= w_rd_area;
            r_w_grey  <= w_rd_grey;
            r_w_fdone <= w_rd_fdone;
            r_w_fval  <= w_rd_fval;
        end
        if (i_cmd.val_calc) begin
            if (r_w_fdone) begin
                r_val <= r_w_fval;
            end else if (r_w_area >= r_thr) begin
                r_val <= r_w_grey;
            end else begin
                r_val <= '0;
            end
            r_u <= r_node;
        end else if (i_cmd.wb_adv) begin
            r_u <= w_rd_parent;
        end
        if (i_cmd.out_load) begin
            r_out_index <= r_raw_idx;
            r_out_value <= GREY_IN_W'(r_val);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RST;
            r_clr       <= '0;
            r_steps     <= '0;
            r_wb_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.rd_node) begin
                r_steps <= '0;
            end else if (i_cmd.step) begin
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.val_calc) begin
                r_wb_cnt <= '0;
            end else if (i_cmd.wb_adv) begin
                r_wb_cnt <= r_wb_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.stop     = !w_rd_pvalid || w_rd_fdone || (r_steps == STEP_W'(NODES));
    assign o_sts.climb    = (r_w_grey == w_rd_grey) || (r_w_area < r_thr);
    assign o_sts.wb_last  = (r_wb_cnt == r_steps);
    assign o_sts.clr_last = (r_clr == IDX_W'(NODES - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;

    `MTAF_ASSERT_NOW(a_step_cap, 1'b1, r_steps <= STEP_W'(NODES),
        "climb ran past the step cap")
    `MTAF_ASSERT_NOW(a_wb_within_path, i_cmd.wb_wr, r_wb_cnt <= r_steps,
        "write-back walked past the climbed path")
    `MTAF_ASSERT_NEXT(a_result_shown, i_cmd.out_load, r_out_valid,
        "loaded result not presented")

endmodule

`default_nettype wire

>>> rtl/maxtree_area_filter.sv
// top level: area opening over a loaded max-tree, one item at a time
// load beat: the index is wrapped and the node written before the next beat is taken
// query beat: climb, write-back, then the result register; D = parent links climbed
//   (at most NODES); each climb and each write-back step costs one node-memory read
// reset: a pass over all NODES entries clears the filter marks before items are taken;
//   area_threshold resets to 1 and the threshold port accepts writes throughout
`default_nettype none

module maxtree_area_filter
    import mtaf_pkg::*;
#(
    parameter int NODES     = NODES_DEF,
    parameter int GREY_BITS = GREY_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtaf_in_if.sink   i_item,
    mtaf_out_if.source o_res,
    mtaf_cfg_if.sink  i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_item.ready = w_in_ready;

    mtaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mtaf_dp #(
        .NODES     (NODES),
        .GREY_BITS (GREY_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item_op           (i_item.op),
        .i_item_node_index   (i_item.node_index),
        .i_item_parent_index (i_item.parent_index),
        .i_item_has_parent   (i_item.has_parent),
        .i_item_area         (i_item.area),
        .i_item_grey         (i_item.grey),
        .i_cfg_valid         (i_cfg.valid),
        .i_cfg_data          (i_cfg.data),
        .o_cfg_ready         (i_cfg.ready),
        .i_out_ready         (o_res.ready),
        .o_out_valid         (o_res.valid),
        .o_out_index         (o_res.out_index),
        .o_out_value         (o_res.filtered_value),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts)
    );

endmodule

`default_nettype wire
